>>> rtl/segment_intersection_core_assert.svh
// assertion macros shared by the segment intersection checker
`ifndef SEGMENT_INTERSECTION_CORE_ASSERT_SVH
`define SEGMENT_INTERSECTION_CORE_ASSERT_SVH

// concurrent check, masked while reset is asserted
`define SIC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("segment intersection check failed");

// concurrent check that also holds across reset
`define SIC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("segment intersection check failed");

`endif

>>> rtl/sic_pkg.sv
// types, widths and status codes for the segment intersection core
`timescale 1ns / 1ps
`default_nettype none

package sic_pkg;

  localparam int CB         = 24;        // coordinate width, Q15.8
  localparam int VW         = CB + 1;    // difference vector width
  localparam int PW         = 2 * VW;    // product width
  localparam int XW         = PW + 1;    // signed cross product width
  localparam int MW         = PW;        // cross product magnitude width
  localparam int RW         = MW + 2;    // partial remainder sum width
  localparam int TW         = 32;        // threshold register width
  localparam int DIV_STAGES = VW;
  localparam int LATENCY    = 3 + 2 + DIV_STAGES + 1;

  typedef enum logic [1:0] {
    ST_HIT      = 2'd0,
    ST_PARALLEL = 2'd1,
    ST_OUTSIDE  = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [CB-1:0] a_start_x;
    logic signed [CB-1:0] a_start_y;
    logic signed [CB-1:0] a_end_x;
    logic signed [CB-1:0] a_end_y;
    logic signed [CB-1:0] b_start_x;
    logic signed [CB-1:0] b_start_y;
    logic signed [CB-1:0] b_end_x;
    logic signed [CB-1:0] b_end_y;
  } in_item_t;

  typedef struct packed {
    status_t              status;
    logic signed [CB-1:0] cross_x;
    logic signed [CB-1:0] cross_y;
  } out_item_t;

  // cross products plus what the point calculation needs later
  typedef struct packed {
    logic signed [XW-1:0] d;
    logic signed [XW-1:0] tn;
    logic signed [XW-1:0] sn;
    logic signed [CB-1:0] p1x;
    logic signed [CB-1:0] p1y;
    logic signed [VW-1:0] v1x;
    logic signed [VW-1:0] v1y;
  } geo_t;

  // classified transaction headed for the divider
  typedef struct packed {
    status_t              status;
    logic [MW-1:0]        n;
    logic [MW-1:0]        d;
    logic [VW-1:0]        ax;
    logic [VW-1:0]        ay;
    logic                 negx;
    logic                 negy;
    logic signed [CB-1:0] p1x;
    logic signed [CB-1:0] p1y;
  } cls_t;

  function automatic logic signed [VW-1:0] sx(input logic signed [CB-1:0] a);
    return {a[CB-1], a};
  endfunction

endpackage

`default_nettype wire

>>> rtl/sic_cross.sv
// difference vectors, products and cross products, three stages
`timescale 1ns / 1ps
`default_nettype none

module sic_cross import sic_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire in_item_t in_item,
  output logic          geo_valid,
  output geo_t          geo
);

  // stage 1: vectors
  logic                 v_valid_r;
  logic signed [VW-1:0] v1x_r, v1y_r, v2x_r, v2y_r, v3x_r, v3y_r;
  logic signed [CB-1:0] p1x_r, p1y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_valid_r <= 1'b0;
    end else begin
      v_valid_r <= in_valid;
    end
    v1x_r <= sx(in_item.a_end_x) - sx(in_item.a_start_x);
    v1y_r <= sx(in_item.a_end_y) - sx(in_item.a_start_y);
    v2x_r <= sx(in_item.b_end_x) - sx(in_item.b_start_x);
    v2y_r <= sx(in_item.b_end_y) - sx(in_item.b_start_y);
    v3x_r <= sx(in_item.b_start_x) - sx(in_item.a_start_x);
    v3y_r <= sx(in_item.b_start_y) - sx(in_item.a_start_y);
    p1x_r <= in_item.a_start_x;
    p1y_r <= in_item.a_start_y;
  end

  // stage 2: six products
  logic                 m_valid_r;
  logic signed [PW-1:0] dpa_r, dpb_r, tpa_r, tpb_r, spa_r, spb_r;
  logic signed [VW-1:0] mv1x_r, mv1y_r;
  logic signed [CB-1:0] mp1x_r, mp1y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
    end else begin
      m_valid_r <= v_valid_r;
    end
    dpa_r  <= v1x_r * v2y_r;
    dpb_r  <= v1y_r * v2x_r;
    tpa_r  <= v3x_r * v2y_r;
    tpb_r  <= v3y_r * v2x_r;
    spa_r  <= v3x_r * v1y_r;
    spb_r  <= v3y_r * v1x_r;
    mv1x_r <= v1x_r;
    mv1y_r <= v1y_r;
    mp1x_r <= p1x_r;
    mp1y_r <= p1y_r;
  end

  // stage 3: differences of products
  logic geo_valid_r;
  geo_t geo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      geo_valid_r <= 1'b0;
    end else begin
      geo_valid_r <= m_valid_r;
    end
    geo_r.d   <= {dpa_r[PW-1], dpa_r} - {dpb_r[PW-1], dpb_r};
    geo_r.tn  <= {tpa_r[PW-1], tpa_r} - {tpb_r[PW-1], tpb_r};
    geo_r.sn  <= {spa_r[PW-1], spa_r} - {spb_r[PW-1], spb_r};
    geo_r.p1x <= mp1x_r;
    geo_r.p1y <= mp1y_r;
    geo_r.v1x <= mv1x_r;
    geo_r.v1y <= mv1y_r;
  end

  assign geo_valid = geo_valid_r;
  assign geo       = geo_r;

endmodule

`default_nettype wire

>>> rtl/sic_classify.sv
// sign normalization and parallel / outside tests, two stages
`timescale 1ns / 1ps
`default_nettype none

module sic_classify import sic_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic [TW-1:0] thr,
  input  wire logic          geo_valid,
  input  wire geo_t          geo,
  output logic               cls_valid,
  output cls_t               cls
);

  // stage 4: flip signs so d is non-negative, vector magnitudes
  logic                 n_valid_r;
  logic                 dzero_r;
  logic signed [XW-1:0] dmag_r, tnn_r, snn_r;
  logic [VW-1:0]        ax_r, ay_r;
  logic                 negx_r, negy_r;
  logic signed [CB-1:0] p1x_r, p1y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_valid_r <= 1'b0;
    end else begin
      n_valid_r <= geo_valid;
    end
    dzero_r <= (geo.d == '0);
    dmag_r  <= geo.d[XW-1] ? -geo.d  : geo.d;
    tnn_r   <= geo.d[XW-1] ? -geo.tn : geo.tn;
    snn_r   <= geo.d[XW-1] ? -geo.sn : geo.sn;
    ax_r    <= geo.v1x[VW-1] ? VW'(-geo.v1x) : VW'(geo.v1x);
    ay_r    <= geo.v1y[VW-1] ? VW'(-geo.v1y) : VW'(geo.v1y);
    negx_r  <= geo.v1x[VW-1];
    negy_r  <= geo.v1y[VW-1];
    p1x_r   <= geo.p1x;
    p1y_r   <= geo.p1y;
  end

  // stage 5: decide status
  logic    parallel, outside;
  status_t status;

  always_comb begin
    parallel = dzero_r || ($unsigned(dmag_r) < XW'(thr));
    outside  = tnn_r[XW-1] || snn_r[XW-1] || (tnn_r > dmag_r) || (snn_r > dmag_r);
    if (parallel) begin
      status = ST_PARALLEL;
    end else if (outside) begin
      status = ST_OUTSIDE;
    end else begin
      status = ST_HIT;
    end
  end

  logic cls_valid_r;
  cls_t cls_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cls_valid_r <= 1'b0;
    end else begin
      cls_valid_r <= n_valid_r;
    end
    cls_r.status <= status;
    cls_r.n      <= tnn_r[MW-1:0];
    cls_r.d      <= dmag_r[MW-1:0];
    cls_r.ax     <= ax_r;
    cls_r.ay     <= ay_r;
    cls_r.negx   <= negx_r;
    cls_r.negy   <= negy_r;
    cls_r.p1x    <= p1x_r;
    cls_r.p1y    <= p1y_r;
  end

  assign cls_valid = cls_valid_r;
  assign cls       = cls_r;

endmodule

`default_nettype wire

>>> rtl/sic_divider.sv
// pipelined floor(|v| * tn / d), one quotient bit per stage, two axis lanes
`timescale 1ns / 1ps
`default_nettype none

module sic_divider import sic_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  cls_valid,
  input  wire cls_t  cls,
  output logic       out_valid,
  output out_item_t  out_item
);

  typedef struct packed {
    logic                      valid;
    status_t                   status;
    logic [MW-1:0]             n;
    logic [MW-1:0]             d;
    logic [1:0][VW-1:0]        a;
    logic [1:0]                neg;
    logic [1:0][CB-1:0]        p;
    logic [1:0][MW-1:0]        r;
    logic [1:0][VW-1:0]        q;
  } dstage_t;

  dstage_t stg_in;
  dstage_t stg_r [DIV_STAGES];

  always_comb begin
    stg_in.valid  = cls_valid;
    stg_in.status = cls.status;
    stg_in.n      = cls.n;
    stg_in.d      = cls.d;
    stg_in.a[0]   = cls.ax;
    stg_in.a[1]   = cls.ay;
    stg_in.neg[0] = cls.negx;
    stg_in.neg[1] = cls.negy;
    stg_in.p[0]   = cls.p1x;
    stg_in.p[1]   = cls.p1y;
    stg_in.r      = '0;
    stg_in.q      = '0;
  end

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    dstage_t cur, stg_nxt;
    logic [RW-1:0] t  [2];
    logic [RW:0]   c1 [2];
    logic [RW:0]   c2 [2];

    if (k == 0) begin : g_first
      assign cur = stg_in;
    end else begin : g_next
      assign cur = stg_r[k-1];
    end

    // remainder stays below d; 2r + n stays below 3d when n <= d, so up to two subtracts
    always_comb begin
      stg_nxt = cur;
      for (int j = 0; j < 2; j++) begin
        t[j]  = {1'b0, cur.r[j], 1'b0}
              + (cur.a[j][DIV_STAGES-1-k] ? RW'(cur.n) : RW'(0));
        c1[j] = {1'b0, t[j]} - {3'b000, cur.d};
        c2[j] = {1'b0, t[j]} - {2'b00, cur.d, 1'b0};
        if (!c2[j][RW]) begin
          stg_nxt.r[j] = c2[j][MW-1:0];
          stg_nxt.q[j] = {cur.q[j][VW-2:0], 1'b0} + VW'(2);
        end else if (!c1[j][RW]) begin
          stg_nxt.r[j] = c1[j][MW-1:0];
          stg_nxt.q[j] = {cur.q[j][VW-2:0], 1'b1};
        end else begin
          stg_nxt.r[j] = t[j][MW-1:0];
          stg_nxt.q[j] = {cur.q[j][VW-2:0], 1'b0};
        end
      end
      // valid bit clears under reset
      if (!rst_n) begin
        stg_nxt.valid = 1'b0;
      end
    end

    always_ff @(posedge clk) begin
      stg_r[k] <= stg_nxt;
    end
  end

  // final stage: step from the start point, zero unless a hit
  dstage_t              last;
  logic signed [CB-1:0] pt [2];
  logic                 out_valid_r;
  out_item_t            out_item_r;

  assign last = stg_r[DIV_STAGES-1];

  always_comb begin
    for (int j = 0; j < 2; j++) begin
      pt[j] = last.neg[j] ? (last.p[j] - CB'(last.q[j])) : (last.p[j] + CB'(last.q[j]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= last.valid;
    end
    out_item_r.status  <= last.status;
    out_item_r.cross_x <= (last.status == ST_HIT) ? pt[0] : '0;
    out_item_r.cross_y <= (last.status == ST_HIT) ? pt[1] : '0;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

>>> rtl/segment_intersection_core.sv
// top level of the 2d segment intersection core
`timescale 1ns / 1ps
`default_nettype none

// the path from accepted start to out_valid runs through 3 cross, 2 classify,
//   25 divider stages and 1 output register
// throughput: one transaction per cycle, every stage is a free-running register
// busy is high only during reset and the cycle after it; the receiver cannot stall
// synchronous active-low reset clears all valid bits and sets the threshold to 1

module segment_intersection_core import sic_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  wire in_item_t      in_item,
  output logic               out_valid,
  output out_item_t          out_item,
  input  wire logic          cfg_we,
  input  wire logic [TW-1:0] cfg_wdata
);

  // parallel threshold register, cross products in 2^-16 units
  logic [TW-1:0] thr_r;
  logic          busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= TW'(1);
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
      if (cfg_we) begin
        thr_r <= cfg_wdata;
      end
    end
  end

  assign busy = busy_r;

  // a transaction enters whenever start is seen while not busy
  logic accept;
  assign accept = start && !busy_r;

  // d = v1 x v2, tn = v3 x v2, sn = v3 x v1
  logic geo_valid;
  geo_t geo;

  sic_cross u_cross (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accept),
    .in_item   (in_item),
    .geo_valid (geo_valid),
    .geo       (geo)
  );

  // parallel when |d| is under threshold or zero, outside when t or s leave [0,1]
  logic cls_valid;
  cls_t cls;

  sic_classify u_classify (
    .clk       (clk),
    .rst_n     (rst_n),
    .thr       (thr_r),
    .geo_valid (geo_valid),
    .geo       (geo),
    .cls_valid (cls_valid),
    .cls       (cls)
  );

  // point = p1 + sign(v1) * floor(|v1| * tn / d), per axis
  sic_divider u_divider (
    .clk       (clk),
    .rst_n     (rst_n),
    .cls_valid (cls_valid),
    .cls       (cls),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

>>> rtl/segment_intersection_core_checker.sv
// port-level checks for the segment intersection core, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

`include "segment_intersection_core_assert.svh"

module segment_intersection_core_checker import sic_pkg::*; (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          start,
  input wire logic          busy,
  input wire in_item_t      in_item,
  input wire logic          out_valid,
  input wire out_item_t     out_item,
  input wire logic          cfg_we,
  input wire logic [TW-1:0] cfg_wdata
);

  logic acc;
  assign acc = start && !busy;

  `SIC_ASSERT(a_miss_zero, clk, rst_n, (out_valid && out_item.status != ST_HIT) |-> (out_item.cross_x == '0 && out_item.cross_y == '0))
  `SIC_ASSERT(a_latency, clk, rst_n, acc |-> ##LATENCY out_valid)
  `SIC_ASSERT(a_busy_clear, clk, rst_n, $past(rst_n) |-> !busy)
  `SIC_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> (!out_valid && busy))

endmodule

bind segment_intersection_core segment_intersection_core_checker u_checker (.*);

`default_nettype wire
